>>> src/adf_pkg.sv
// shared types, constants and header byte table for the artdmx packet framer
`default_nettype none

package adf_pkg;

    localparam int unsigned C_HDR_LEN  = 18;
    localparam int unsigned C_IDX_W    = 5;
    localparam int unsigned C_LEN_W    = 10;
    localparam int unsigned C_MIN_LEN  = 2;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [7:0] C_OPCODE_HI = 8'h50;
    localparam logic [7:0] C_PROT_VER  = 8'd14;
    localparam logic [7:0] C_SEQ_MAX   = 8'd255;
    localparam logic [7:0] C_SEQ_FIRST = 8'd1;

    typedef logic [C_IDX_W-1:0] t_idx;
    typedef logic [C_LEN_W-1:0] t_len;

    // one unit of output work: a header (plus padding) or one data byte (plus padding)
    typedef struct packed {
        logic        vld;
        logic        is_begin;
        logic [7:0]  seq;
        logic [14:0] universe;
        t_len        len;
        logic [7:0]  data;
        t_idx        last;
        logic        last_end;
    } t_job;

    function automatic logic [7:0] hdr_byte(
        input t_idx        idx,
        input logic [7:0]  seq,
        input logic [14:0] universe,
        input t_len        len
    );
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h41; // A
            5'd1:    b = 8'h72; // r
            5'd2:    b = 8'h74; // t
            5'd3:    b = 8'h2D; // -
            5'd4:    b = 8'h4E; // N
            5'd5:    b = 8'h65; // e
            5'd6:    b = 8'h74; // t
            5'd9:    b = C_OPCODE_HI;
            5'd11:   b = C_PROT_VER;
            5'd12:   b = seq;
            5'd14:   b = universe[7:0];
            5'd15:   b = {1'b0, universe[14:8]};
            5'd16:   b = {6'b0, len[9:8]};
            5'd17:   b = len[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> src/adf_if.sv
// valid/ready channel interfaces for input items, output bytes and the enable register
`default_nettype none

interface adf_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [14:0] universe;
    logic [9:0]  channel_count;
    logic [7:0]  data_byte;

    modport source (output valid, command, universe, channel_count, data_byte, input ready);
    modport sink   (input valid, command, universe, channel_count, data_byte, output ready);
endinterface

interface adf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;

    modport source (output valid, out_byte, packet_end, input ready);
    modport sink   (input valid, out_byte, packet_end, output ready);
endinterface

interface adf_cfg_if;
    logic valid;
    logic ready;
    logic output_enable;

    modport source (output valid, output_enable, input ready);
    modport sink   (input valid, output_enable, output ready);
endinterface

`default_nettype wire

>>> src/artdmx_packet_framer.sv
// top level of the artdmx packet framer
//
// i_in carries items: command 0 begins a packet (universe, channel_count),
// command 1 carries one channel byte. o_out streams the packet payload one
// byte per transfer, with packet_end on the final byte. i_cfg writes the
// output enable bit; it is always ready. With enable low every item is
// accepted and dropped.
// A begin item yields 18 header bytes (20 when no channel bytes follow);
// a channel byte yields one byte, or two when a zero pad byte closes the
// packet. Data bytes past the requested count are dropped.
// The first byte of an item passes through the job register and then the
// output register to o_out. While o_out is not stalled, the output side moves
// one byte per cycle and one channel byte is taken per cycle; a begin item
// keeps i_in.ready low while the header counter runs.
// A stall on o_out holds the output register and, through it, the job
// register and i_in.ready. Reset clears the enable, open packet state and
// both valids, and sets the sequence byte to 1.
`default_nettype none

module artdmx_packet_framer #(
    parameter int unsigned MAX_CHANNELS = 512
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    adf_in_if.sink    i_in,
    adf_cfg_if.sink   i_cfg,
    adf_out_if.source o_out
);
    import adf_pkg::*;

    t_job job;
    logic done;

    adf_decoder #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_done  (done),
        .o_job   (job)
    );

    adf_emitter u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job),
        .o_done  (done),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> src/adf_decoder.sv
// input register and packet state: turns accepted items into output jobs (none while disabled or past the count)
`default_nettype none

module adf_decoder #(
    parameter int unsigned MAX_CHANNELS = 512
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    adf_in_if.sink             i_in,
    adf_cfg_if.sink            i_cfg,
    input  wire logic          i_done,
    output adf_pkg::t_job      o_job
);
    import adf_pkg::*;

    localparam t_len L_MAX = C_LEN_W'(MAX_CHANNELS);
    localparam t_len L_MIN = C_LEN_W'(C_MIN_LEN);
    localparam t_idx L_HDR_LAST = C_IDX_W'(C_HDR_LEN - 1);

    logic       r_enable;
    logic [7:0] r_seq,       n_seq;
    logic       r_active,    n_active;
    t_len       r_taken,     n_taken;
    t_len       r_req,       n_req;
    t_len       r_plen,      n_plen;
    t_job       r_job,       n_job;

    logic accept;
    t_len len_clamp;
    t_len len;
    t_len req;
    t_len taken_next;
    t_len pad_left;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_job.vld || i_done;
    assign accept      = i_in.valid && i_in.ready;
    assign o_job       = r_job;

    always_comb begin
        if (i_in.channel_count < L_MIN) begin
            len_clamp = L_MIN;
        end else if (i_in.channel_count > L_MAX) begin
            len_clamp = L_MAX;
        end else begin
            len_clamp = i_in.channel_count;
        end
        // round up to even
        len        = len_clamp + t_len'(len_clamp[0]);
        req        = (i_in.channel_count < len) ? i_in.channel_count : len;
        taken_next = r_taken + t_len'(1);
        pad_left   = r_plen - taken_next;
    end

    always_comb begin
        n_seq    = r_seq;
        n_active = r_active;
        n_taken  = r_taken;
        n_req    = r_req;
        n_plen   = r_plen;
        n_job    = r_job;
        n_job.vld = r_job.vld && !i_done;

        if (accept && r_enable) begin
            if (i_in.command == CMD_BEGIN) begin
                n_job.vld      = 1'b1;
                n_job.is_begin = 1'b1;
                n_job.seq      = r_seq;
                n_job.universe = i_in.universe;
                n_job.len      = len;
                n_job.data     = i_in.data_byte;
                n_job.last     = (req == '0) ? L_HDR_LAST + C_IDX_W'(len) : L_HDR_LAST;
                n_job.last_end = (req == '0);
                n_seq    = (r_seq >= C_SEQ_MAX || r_seq == '0) ? C_SEQ_FIRST
                                                                : r_seq + 8'd1;
                n_plen   = len;
                n_req    = req;
                n_taken  = '0;
                n_active = (req != '0);
            end else if (r_active) begin
                n_job.vld      = 1'b1;
                n_job.is_begin = 1'b0;
                n_job.data     = i_in.data_byte;
                n_taken        = taken_next;
                if (taken_next >= r_req) begin
                    n_job.last     = C_IDX_W'(pad_left);
                    n_job.last_end = (pad_left != '0) || (taken_next == r_plen);
                    n_active       = 1'b0;
                end else begin
                    n_job.last     = '0;
                    n_job.last_end = (taken_next == r_plen);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_seq     <= C_SEQ_FIRST;
            r_active  <= 1'b0;
            r_taken   <= '0;
            r_req     <= '0;
            r_plen    <= '0;
            r_job     <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_enable <= i_cfg.output_enable;
            end
            r_seq     <= n_seq;
            r_active  <= n_active;
            r_taken   <= n_taken;
            r_req     <= n_req;
            r_plen    <= n_plen;
            r_job     <= n_job;
        end
    end

endmodule

`default_nettype wire

>>> src/adf_emitter.sv
// byte counter over the current job and the output register
`default_nettype none

module adf_emitter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire adf_pkg::t_job i_job,
    output logic               o_done,
    adf_out_if.source          o_out
);
    import adf_pkg::*;

    t_idx       r_idx;
    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic       r_out_end;

    logic       emit;
    logic       at_last;
    logic [7:0] byte_sel;

    assign emit    = i_job.vld && (!r_out_vld || o_out.ready);
    assign at_last = (r_idx == i_job.last);
    assign o_done  = emit && at_last;

    always_comb begin
        if (i_job.is_begin) begin
            byte_sel = (r_idx < C_IDX_W'(C_HDR_LEN))
                     ? hdr_byte(r_idx, i_job.seq, i_job.universe, i_job.len) : 8'h00;
        end else begin
            byte_sel = (r_idx == '0) ? i_job.data : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_done) begin
                r_idx <= '0;
            end else if (emit) begin
                r_idx <= r_idx + t_idx'(1);
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= byte_sel;
            r_out_end  <= at_last && i_job.last_end;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.packet_end = r_out_end;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job.vld |-> r_idx <= i_job.last)
        else $error("byte index ran past the last byte of the job");

    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job.vld && !o_done) |=> i_job.vld)
        else $error("job dropped before its last byte was sent");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_vld)
        else $error("emitted byte not held in the output register");

    a_data_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job.vld && !i_job.is_begin) |-> i_job.last <= t_idx'(1))
        else $error("data job longer than two bytes");

endmodule

`default_nettype wire

>>> dv/artdmx_packet_framer_test.sv
// self-checking testbench for the artdmx packet framer against a byte predictor
module artdmx_packet_framer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import adf_pkg::*;

    localparam int MAX_CH      = 512;
    localparam int SETTLE      = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        cmd;
        logic [14:0] uni;
        logic [9:0]  cnt;
        logic [7:0]  dat;
    } dmx_item_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } pay_byte_t;

    logic clk;
    logic rst_n;

    adf_in_if  in_ch();
    adf_cfg_if cfg_ch();
    adf_out_if out_ch();

    artdmx_packet_framer #(
        .MAX_CHANNELS(MAX_CH)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    dmx_item_t item_q[$];
    pay_byte_t payload_q[$];
    int        n_queued = 0;
    int        err_cnt  = 0;
    logic      in_up    = 1'b0;
    logic      steady   = 1'b0;
    logic      cfg_done = 1'b0;

    // predictor state
    logic       mdl_en    = 1'b0;
    logic [7:0] mdl_seq   = C_SEQ_FIRST;
    logic       mdl_open  = 1'b0;
    int         mdl_taken = 0;
    int         mdl_want  = 0;
    int         mdl_len   = 0;

    logic [7:0] art_id [7] = '{8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74};

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic expect_byte(input logic [7:0] b, input logic last);
        pay_byte_t p;
        p.b    = b;
        p.last = last;
        payload_q.push_back(p);
    endtask

    // zero fill up to the packet length, last one marked
    task automatic pad_frame();
        for (int i = mdl_taken; i < mdl_len; i++)
            expect_byte(8'h00, (i + 1) == mdl_len);
        mdl_open = 1'b0;
    endtask

    task automatic frame_item(input dmx_item_t it);
        int len;
        if (!mdl_en)
            return;
        if (it.cmd == CMD_BEGIN) begin
            len = int'(it.cnt);
            if (len < C_MIN_LEN)
                len = C_MIN_LEN;
            if (len > MAX_CH)
                len = MAX_CH;
            if (len % 2)
                len++;
            for (int i = 0; i < 7; i++)
                expect_byte(art_id[i], 1'b0);
            expect_byte(8'h00, 1'b0);
            expect_byte(8'h00, 1'b0);
            expect_byte(C_OPCODE_HI, 1'b0);
            expect_byte(8'h00, 1'b0);
            expect_byte(C_PROT_VER, 1'b0);
            expect_byte(mdl_seq, 1'b0);
            if (mdl_seq >= C_SEQ_MAX || mdl_seq == 8'd0)
                mdl_seq = C_SEQ_FIRST;
            else
                mdl_seq = mdl_seq + 8'd1;
            expect_byte(8'h00, 1'b0);
            expect_byte(it.uni[7:0], 1'b0);
            expect_byte({1'b0, it.uni[14:8]}, 1'b0);
            expect_byte(8'((len >> 8) & 8'hFF), 1'b0);
            expect_byte(8'(len & 8'hFF), 1'b0);
            mdl_len   = len;
            mdl_want  = (int'(it.cnt) < len) ? int'(it.cnt) : len;
            mdl_taken = 0;
            mdl_open  = 1'b1;
            if (mdl_want == 0)
                pad_frame();
        end else if (mdl_open) begin
            mdl_taken++;
            expect_byte(it.dat, mdl_taken == mdl_len);
            if (mdl_taken >= mdl_want)
                pad_frame();
        end
    endtask

    // input side: fed from item_q, stimulus changes on the falling edge
    always @(negedge clk) begin : drv
        dmx_item_t nx;
        if (rst_n && !in_up && item_q.size() != 0 && (steady || $urandom_range(0, 99) >= 8)) begin
            nx = item_q.pop_front();
            in_ch.command       <= nx.cmd;
            in_ch.universe      <= nx.uni;
            in_ch.channel_count <= nx.cnt;
            in_ch.data_byte     <= nx.dat;
            in_up = 1'b1;
        end
        in_ch.valid  <= in_up;
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge clk) begin : mon
        dmx_item_t it;
        pay_byte_t want;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                mdl_en   = cfg_ch.output_enable;
                cfg_done = 1'b1;
            end
            if (in_ch.valid && in_ch.ready) begin
                it.cmd = in_ch.command;
                it.uni = in_ch.universe;
                it.cnt = in_ch.channel_count;
                it.dat = in_ch.data_byte;
                frame_item(it);
                in_up = 1'b0;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (payload_q.size() == 0) begin
                    $error("unexpected transfer: out_byte %02h packet_end %0b",
                           out_ch.out_byte, out_ch.packet_end);
                    err_cnt++;
                end else begin
                    want = payload_q.pop_front();
                    if (out_ch.out_byte !== want.b) begin
                        $error("out_byte: expected %02h, actual %02h", want.b, out_ch.out_byte);
                        err_cnt++;
                    end
                    if (out_ch.packet_end !== want.last) begin
                        $error("packet_end: expected %0b, actual %0b",
                               want.last, out_ch.packet_end);
                        err_cnt++;
                    end
                end
            end
        end
    end

    task automatic add_begin(input logic [14:0] uni, input int cnt);
        dmx_item_t it;
        it.cmd = CMD_BEGIN;
        it.uni = uni;
        it.cnt = 10'(cnt);
        it.dat = 8'($urandom_range(0, 255));
        item_q.push_back(it);
        n_queued++;
    endtask

    task automatic add_data(input logic [7:0] dat);
        dmx_item_t it;
        it.cmd = CMD_DATA;
        it.uni = 15'($urandom_range(0, 32767));
        it.cnt = 10'($urandom_range(0, 1023));
        it.dat = dat;
        item_q.push_back(it);
        n_queued++;
    endtask

    task automatic rand_traffic(input int n);
        int target;
        int sel;
        int cnt;
        int nd;
        target = n_queued + n;
        while (n_queued < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                // packet, full when the count is at most 40, sometimes with extra bytes past the count
                sel = $urandom_range(0, 99);
                cnt = (sel < 50) ? $urandom_range(0, 8) :
                      (sel < 90) ? $urandom_range(9, 40) : $urandom_range(41, 1023);
                nd = (cnt > 40) ? $urandom_range(0, 40) : cnt;
                if ($urandom_range(0, 99) < 15)
                    nd += $urandom_range(1, 3);
                add_begin(15'($urandom_range(0, 32767)), cnt);
                repeat (nd) add_data(8'($urandom_range(0, 255)));
            end else if (sel < 90) begin
                // begin that the next begin will cut short
                add_begin(15'($urandom_range(0, 32767)), $urandom_range(0, 1023));
                repeat ($urandom_range(0, 6)) add_data(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3)) add_data(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_idle();
        while (item_q.size() != 0 || in_up || payload_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_enable(input logic v);
        @(negedge clk);
        cfg_done = 1'b0;
        cfg_ch.valid         <= 1'b1;
        cfg_ch.output_enable <= v;
        wait (cfg_done);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : ctrl
        in_ch.valid          = 1'b0;
        in_ch.command        = CMD_BEGIN;
        in_ch.universe       = '0;
        in_ch.channel_count  = '0;
        in_ch.data_byte      = '0;
        out_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.output_enable = 1'b0;
        rst_n                = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // output still closed after reset: all of this is dropped
        rand_traffic(10);
        wait_idle();
        write_enable(1'b1);

        // directed
        add_data(8'hA5);
        add_begin(15'h0000, 0);
        add_begin(15'h7FFF, 1);
        add_data(8'hFF);
        add_begin(15'h0100, 2);
        add_data(8'h00);
        add_data(8'hFF);
        add_begin(15'h00FF, 3);
        add_data(8'h01);
        add_data(8'h02);
        add_data(8'h03);
        add_data(8'h04);
        add_begin(15'h5555, 1023);
        add_data(8'h80);
        add_data(8'h7F);
        add_begin(15'h2AAA, 5);
        repeat (5) add_data(8'($urandom_range(0, 255)));
        wait_idle();

        rand_traffic(20);
        // sender holds off until the output drains, possibly mid-packet
        wait_idle();

        // closing the port must leave the open packet untouched
        write_enable(1'b0);
        rand_traffic(5);
        wait_idle();
        write_enable(1'b1);

        steady = 1'b1;
        rand_traffic(20);
        wait_idle();
        steady = 1'b0;

        // enough begins to wrap the sequence byte past 255
        for (int i = 0; i < 250; i++)
            add_begin(15'($urandom_range(0, 32767)), $urandom_range(0, 1));
        wait_idle();

        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
src/adf_pkg.sv
src/adf_if.sv
src/adf_decoder.sv
src/adf_emitter.sv
src/artdmx_packet_framer.sv
dv/artdmx_packet_framer_test.sv
